[design/sha256_hash_core_macros.svh]
// Assertion macros for the SHA-256 hash core.
// No dependencies.
`ifndef SHA256_HASH_CORE_MACROS_SVH
`define SHA256_HASH_CORE_MACROS_SVH
// Clocked implication with reset disable.
`define SHC_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication with reset disable.
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

[design/shc_pkg.sv]
// Package for the SHA-256 hash core: types, constants, round functions.
// No dependencies.
`default_nettype none
package shc_pkg;
    localparam logic [31:0] PadWord = 32'h8000_0000;

    // Padding phase codes
    localparam logic [3:0] PadDone  = 4'd0;
    localparam logic [3:0] PadLenLo = 4'd1;
    localparam logic [3:0] PadLenHi = 4'd2;
    localparam logic [3:0] PadZero  = 4'd14;
    localparam logic [3:0] PadMark  = 4'd15;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_PAD, t_ST_LOAD, t_ST_ROUND, t_ST_FOLD, t_ST_OUT
    } t_state;

    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [31:0] wdata;
        logic [3:0] raddr;
    } t_mem_req;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667; 3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372; 3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f; 3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab; default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
    function automatic logic [31:0] ss0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction
    function automatic logic [31:0] ss1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction
    function automatic logic [31:0] bs0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction
    function automatic logic [31:0] bs1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage
`default_nettype wire

[design/sha256_hash_core.sv]
// SHA-256 hash core top level: input packing, padding, round engine, output.
// Depends on shc_pkg, shc_sched and sha256_hash_core_macros.svh.
//
//  channel | direction | signals
//  in      | sink      | i_valid, o_stall, i_msg_word, i_valid_bytes, i_last_word
//  out     | source    | o_valid, i_stall, o_digest_word, o_digest_last
//
// Flow: the word that fills a block stalls the input through a load step, 64 rounds
// (W from the window memory for t<16, else from the shift line) and the fold.
// The final word adds padding words, one per cycle, and one or two compressions.
// Eight digest items then leave one per cycle; stall on the output holds them.
// Reset restores the initial chaining value; the window memory is not cleared.
`default_nettype none
`include "sha256_hash_core_macros.svh"
module sha256_hash_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_msg_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic             o_digest_last
);
    shc_pkg::t_state r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];   // shift line of the last sixteen W values
    logic [3:0]  r_cnt;      // words in the current block
    logic [63:0] r_len;
    logic [6:0]  r_t;        // load/round index
    logic        r_final;    // digest goes out after this compression
    logic [3:0]  r_pad;      // padding phase
    logic [2:0]  r_oi;
    logic [31:0] w_rdata;
    shc_pkg::t_mem_req w_req;

    shc_sched u_sched (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    wire w_acc = i_valid && !o_stall;
    logic [2:0] w_nb;
    logic [31:0] w_first, w_padw, w_push;
    logic w_pushing;
    always_comb begin
        w_nb = (i_valid_bytes > 3'd4 || !i_last_word) ? 3'd4 : i_valid_bytes;
        w_first = i_msg_word;
        if (i_last_word && w_nb != 3'd4)
            w_first = (w_nb == 3'd0 ? 32'd0 : (i_msg_word & (32'hffffffff << (6'd32 - 6'(w_nb) * 6'd8))))
                    | (32'h80 << (5'd24 - 5'(w_nb) * 5'd8));
        // padding word for the current phase
        if (r_pad == shc_pkg::PadLenHi) w_padw = r_len[63:32];
        else if (r_pad == shc_pkg::PadLenLo) w_padw = r_len[31:0];
        else w_padw = (r_pad == shc_pkg::PadMark) ? shc_pkg::PadWord : 32'd0;
        w_pushing = (r_state == shc_pkg::t_ST_IDLE && w_acc) || r_state == shc_pkg::t_ST_PAD;
        w_push = (r_state == shc_pkg::t_ST_PAD) ? w_padw : w_first;
    end

    // round W: from memory for t<16, else from the schedule line
    logic [31:0] w_wt, w_new, w_t1, w_t2;
    always_comb begin
        w_new = shc_pkg::ss1(r_w[14]) + r_w[9] + shc_pkg::ss0(r_w[1]) + r_w[0];
        w_wt = (r_t < 7'd16) ? w_rdata : w_new;
        w_t1 = r_v[7] + shc_pkg::bs1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + shc_pkg::RoundK[r_t[5:0]] + w_wt;
        w_t2 = shc_pkg::bs0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        w_req.we = w_pushing;
        w_req.waddr = r_cnt;
        w_req.wdata = w_push;
        w_req.raddr = (r_state == shc_pkg::t_ST_LOAD) ? 4'd0 : (r_t[3:0] + 4'd1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shc_pkg::t_ST_IDLE: if (w_acc) begin
                if (r_cnt == 4'd15) n_state = shc_pkg::t_ST_LOAD;
                else if (i_last_word) n_state = shc_pkg::t_ST_PAD;
            end
            shc_pkg::t_ST_PAD: if (r_cnt == 4'd15) n_state = shc_pkg::t_ST_LOAD;
            shc_pkg::t_ST_LOAD: n_state = shc_pkg::t_ST_ROUND;
            shc_pkg::t_ST_ROUND: if (r_t == 7'd63) n_state = shc_pkg::t_ST_FOLD;
            shc_pkg::t_ST_FOLD: n_state = (r_pad != shc_pkg::PadDone) ? shc_pkg::t_ST_PAD :
                                          r_final ? shc_pkg::t_ST_OUT : shc_pkg::t_ST_IDLE;
            shc_pkg::t_ST_OUT: if (!i_stall && r_oi == 3'd7) n_state = shc_pkg::t_ST_IDLE;
            default: n_state = shc_pkg::t_ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = (r_state != shc_pkg::t_ST_IDLE);
        o_valid = (r_state == shc_pkg::t_ST_OUT);
        o_digest_word = r_h[r_oi];
        o_digest_last = (r_oi == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shc_pkg::t_ST_IDLE;
            r_cnt <= '0; r_len <= '0; r_t <= '0; r_final <= 1'b0; r_pad <= shc_pkg::PadDone;
            r_oi <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= shc_pkg::init_hash(3'(i)); r_v[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_pushing) r_cnt <= r_cnt + 4'd1;
            if (r_state == shc_pkg::t_ST_IDLE && w_acc) begin
                r_len <= r_len + 64'(w_nb) * 64'd8;
                if (i_last_word) begin
                    r_final <= 1'b1;
                    // a full final word still needs the 0x80 word; a short one in
                    // slot 13 goes straight to the length words
                    if (w_nb == 3'd4) r_pad <= shc_pkg::PadMark;
                    else if (r_cnt == 4'd13) r_pad <= shc_pkg::PadLenHi;
                    else r_pad <= shc_pkg::PadZero;
                end
            end
            if (r_state == shc_pkg::t_ST_PAD) begin
                // marker word, zeros until slot 14, then the two length words
                case (r_pad)
                    shc_pkg::PadMark:
                        r_pad <= (r_cnt == 4'd13) ? shc_pkg::PadLenHi : shc_pkg::PadZero;
                    shc_pkg::PadZero: if (r_cnt == 4'd13) r_pad <= shc_pkg::PadLenHi;
                    shc_pkg::PadLenHi: r_pad <= shc_pkg::PadLenLo;
                    default: r_pad <= shc_pkg::PadDone;
                endcase
            end
            if (r_state == shc_pkg::t_ST_LOAD) begin
                r_t <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            if (r_state == shc_pkg::t_ST_ROUND) begin
                r_t <= r_t + 7'd1;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_wt;
                r_v[0] <= w_t1 + w_t2; r_v[1] <= r_v[0]; r_v[2] <= r_v[1]; r_v[3] <= r_v[2];
                r_v[4] <= r_v[3] + w_t1; r_v[5] <= r_v[4]; r_v[6] <= r_v[5]; r_v[7] <= r_v[6];
            end
            if (r_state == shc_pkg::t_ST_FOLD)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            if (r_state == shc_pkg::t_ST_OUT && !i_stall) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    // drop back to the initial chaining value for the next message
                    r_final <= 1'b0; r_len <= '0; r_cnt <= '0;
                    for (int i = 0; i < 8; i++) r_h[i] <= shc_pkg::init_hash(3'(i));
                end
            end
        end
    end

    `SHC_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != shc_pkg::t_ST_IDLE, o_stall, "input taken while busy")
    `SHC_ASSERT_IMPL(a_out_final, i_clk, i_rst_n, o_valid, r_final, "digest without final word")
    `SHC_ASSERT_NEXT(a_fold_after_round, i_clk, i_rst_n, r_state == shc_pkg::t_ST_ROUND && r_t == 7'd63, r_state == shc_pkg::t_ST_FOLD, "round count slip")
endmodule
`default_nettype wire

[design/shc_sched.sv]
// Message schedule: 16-entry window memory of W with a registered read port.
// Depends on shc_pkg.
`default_nettype none
module shc_sched (
    input  wire logic             i_clk,
    input  wire shc_pkg::t_mem_req i_req,
    output logic [31:0]           o_rdata
);
    logic [31:0] r_mem [16];
    always_ff @(posedge i_clk) begin
        if (i_req.we) r_mem[i_req.waddr] <= i_req.wdata;
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule
`default_nettype wire
